### rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and the phase pin table of the I2C master byte engine.
// No dependencies; imported by the front end, queue, engine, top level and testbench.
package i2cm_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PHASE_W     = 2;
  localparam int unsigned BIT_CNT_W   = 4;
  localparam int unsigned QDEPTH      = 2;   // power of two
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_NACK = 3'd5;

  localparam logic [PHASE_W-1:0] PH_BIT_LOW  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BIT_HIGH = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 2'd3;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [BYTE_W-1:0]    PHASE_TICKS_RESET = 8'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] tx_byte;
    logic              sda_sample;
  } item_t;

  typedef struct packed {
    logic scl;
    logic pull;
  } pins_t;

  // Pin levels held during a phase, given the command, phase and data MSB.
  function automatic pins_t enter_pins(logic [CMD_W-1:0] op, logic [PHASE_W-1:0] ph,
                                       logic msb);
    pins_t p;
    p.scl  = ph[0];
    p.pull = 1'b0;
    unique case (op)
      CMD_START: begin
        p.scl  = 1'b1;
        p.pull = ph[0];
      end
      CMD_STOP: begin
        p.scl  = (ph != PH_BIT_LOW);
        p.pull = (ph != PH_ACK_LOW);
      end
      CMD_WRITE: begin
        p.pull = !ph[1] && !msb;
      end
      default: begin
        p.pull = ph[1] && (op == CMD_READ_ACK);
      end
    endcase
    return p;
  endfunction

endpackage

### rtl/core/i2cm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the I2C master byte engine: commands, results, config.
// No dependencies.
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       sda_sample;
  modport source (output valid, cmd, tx_byte, sda_sample, input ready);
  modport sink   (input valid, cmd, tx_byte, sda_sample, output ready);
endinterface

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       engine_busy;
  logic       cmd_done;
  logic [7:0] rx_byte;
  logic       nack_seen;
  modport source (output valid, scl_level, sda_pull_low, engine_busy, cmd_done, rx_byte,
                  nack_seen, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, engine_busy, cmd_done, rx_byte,
                  nack_seen, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] phase_ticks;
  modport source (output valid, phase_ticks, input ready);
  modport sink   (input valid, phase_ticks, output ready);
endinterface

### rtl/core/i2cm_front.sv
`timescale 1ns / 1ps
// Front end: accepts command items and classifies the opcode for the engine.
// Depends on i2cm_pkg and i2cm_cmd_if.
module i2cm_front (
  i2cm_cmd_if.sink        cmd_i,
  input  logic            push_ready_i,
  output logic            push_valid_o,
  output i2cm_pkg::item_t push_item_o
);
  import i2cm_pkg::*;

  logic known_cmd;

  // Codes above read-with-nack carry no command: treat them as plain ticks.
  assign known_cmd = (cmd_i.cmd == CMD_START) || (cmd_i.cmd == CMD_STOP) ||
                     (cmd_i.cmd == CMD_WRITE) || (cmd_i.cmd == CMD_READ_ACK) ||
                     (cmd_i.cmd == CMD_READ_NACK);

  assign cmd_i.ready             = push_ready_i;
  assign push_valid_o            = cmd_i.valid;
  assign push_item_o.op          = known_cmd ? cmd_i.cmd : CMD_TICK;
  assign push_item_o.tx_byte     = cmd_i.tx_byte;
  assign push_item_o.sda_sample  = cmd_i.sda_sample;

endmodule

### rtl/core/i2cm_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between front end and engine.
// Depends on i2cm_pkg.
module i2cm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  i2cm_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output i2cm_pkg::item_t pop_item_o,
  input  logic            pop_ready_i
);
  import i2cm_pkg::*;

  item_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = QCNT_W'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = QCNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

### rtl/core/i2cm_back.sv
`timescale 1ns / 1ps
// Engine: runs the SCL/SDA phase sequencer one item per step and registers the result.
// Depends on i2cm_pkg, i2cm_rsp_if and i2cm_cfg_if.
module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  i2cm_pkg::item_t pop_item_i,
  output logic            pop_ready_o,
  i2cm_cfg_if.sink        cfg_i,
  i2cm_rsp_if.source      rsp_o
);
  import i2cm_pkg::*;

  logic [BYTE_W-1:0]    phase_ticks_q;
  logic [BYTE_W-1:0]    limit;
  logic [CMD_W-1:0]     active_q, active_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [BYTE_W-1:0]    tick_q, tick_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;
  logic [BYTE_W-1:0]    shift_q, shift_d;
  pins_t                pins_q, pins_d, out_pins;
  logic [BYTE_W-1:0]    rx_q, rx_d;
  logic                 nack_q, nack_d;
  logic                 busy, done, finish, is_read;
  logic                 step;
  logic                 rsp_valid_q;
  logic                 rsp_scl_q, rsp_pull_q, rsp_busy_q, rsp_done_q;

  assign cfg_i.ready = 1'b1;
  assign limit       = (phase_ticks_q == '0) ? BYTE_W'(1) : phase_ticks_q;

  // Step whenever an item waits and the result register is free or draining.
  assign step        = pop_valid_i && (!rsp_valid_q || rsp_o.ready);
  assign pop_ready_o = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    pins_d   = pins_q;
    rx_d     = rx_q;
    nack_d   = nack_q;
    done     = 1'b0;
    finish   = 1'b0;
    if (active_q == CMD_TICK && pop_item_i.op != CMD_TICK) begin
      active_d = pop_item_i.op;
      phase_d  = PH_BIT_LOW;
      tick_d   = '0;
      bit_d    = '0;
      shift_d  = (pop_item_i.op == CMD_WRITE) ? pop_item_i.tx_byte : '0;
      pins_d   = enter_pins(pop_item_i.op, PH_BIT_LOW, shift_d[BYTE_W-1]);
    end
    out_pins = pins_d;
    busy     = (active_d != CMD_TICK);
    is_read  = (active_d == CMD_READ_ACK) || (active_d == CMD_READ_NACK);
    if (busy) begin
      tick_d = BYTE_W'(tick_d + 1'b1);
      if (tick_d >= limit) begin
        tick_d = '0;
        priority if (active_d == CMD_START) begin
          if (phase_d == PH_BIT_LOW) begin
            phase_d = PH_BIT_HIGH;
          end else begin
            pins_d = '{scl: 1'b0, pull: 1'b1};
            finish = 1'b1;
          end
        end else if (active_d == CMD_STOP) begin
          if (phase_d != PH_ACK_LOW) begin
            phase_d = PHASE_W'(phase_d + 1'b1);
          end else begin
            finish = 1'b1;
          end
        end else if (phase_d == PH_BIT_LOW || phase_d == PH_ACK_LOW) begin
          phase_d = PHASE_W'(phase_d + 1'b1);
        end else if (phase_d == PH_BIT_HIGH) begin
          // Sample on the last tick of SCL high; a write just advances the MSB.
          shift_d = {shift_d[BYTE_W-2:0], is_read && pop_item_i.sda_sample};
          bit_d   = BIT_CNT_W'(bit_d + 1'b1);
          phase_d = (bit_d >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
        end else begin
          if (is_read) begin
            rx_d = shift_d;
          end else begin
            nack_d = pop_item_i.sda_sample;
          end
          pins_d = '{scl: 1'b0, pull: 1'b0};
          finish = 1'b1;
        end
        if (finish) begin
          done     = 1'b1;
          active_d = CMD_TICK;
          phase_d  = PH_BIT_LOW;
          bit_d    = '0;
        end else begin
          pins_d = enter_pins(active_d, phase_d, shift_d[BYTE_W-1]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RESET;
      active_q      <= CMD_TICK;
      phase_q       <= PH_BIT_LOW;
      tick_q        <= '0;
      bit_q         <= '0;
      shift_q       <= '0;
      pins_q        <= '{scl: 1'b1, pull: 1'b0};
      rx_q          <= '0;
      nack_q        <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        phase_ticks_q <= cfg_i.phase_ticks;
      end
      if (step) begin
        active_q    <= active_d;
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        pins_q      <= pins_d;
        rx_q        <= rx_d;
        nack_q      <= nack_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: rx and nack come straight from their state registers.
  always_ff @(posedge clk_i) begin
    if (step) begin
      rsp_scl_q  <= out_pins.scl;
      rsp_pull_q <= out_pins.pull;
      rsp_busy_q <= busy;
      rsp_done_q <= done;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.scl_level    = rsp_scl_q;
  assign rsp_o.sda_pull_low = rsp_pull_q;
  assign rsp_o.engine_busy  = rsp_busy_q;
  assign rsp_o.cmd_done     = rsp_done_q;
  assign rsp_o.rx_byte      = rx_q;
  assign rsp_o.nack_seen    = nack_q;

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && done |=> active_q == CMD_TICK)
    else $error("engine not idle after command completion");

  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && done |-> busy)
    else $error("completion flagged outside a command");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == CMD_TICK |-> phase_q == PH_BIT_LOW && bit_q == '0)
    else $error("idle engine holds stale phase or bit count");

  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BITS_PER_BYTE)
    else $error("bit count past one byte");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(active_q) && $stable(tick_q) && $stable(shift_q))
    else $error("engine state moved without a step");

endmodule

### rtl/core/i2c_master_byte_engine_top.sv
`timescale 1ns / 1ps
// Top level of the I2C master byte engine: front end, item queue and phase engine.
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue and i2cm_back.
//
//   channel  dir  handshake          payload
//   cmd_i    in   valid/ready        cmd[2:0], tx_byte[7:0], sda_sample
//   rsp_o    out  valid/ready        scl_level, sda_pull_low, engine_busy, cmd_done,
//                                    rx_byte[7:0], nack_seen
//   cfg_i    in   valid/ready(=1)    phase_ticks[7:0]
//
// One item per cycle sustained while rsp_o takes results; each item is one engine step. An item
// is written into a queue slot and the engine steps on it from there, so its result is
// registered in the result register, from which it can be taken.
// A two-entry queue lets the front accept while the result register is stalled; cmd_i
// ready drops once both slots hold items. Reset leaves SCL released high, SDA released,
// phase_ticks at 3 and the engine idle; no clearing pass is needed.
module i2c_master_byte_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_cmd_if.sink    cmd_i,
  i2cm_cfg_if.sink    cfg_i,
  i2cm_rsp_if.source  rsp_o
);
  import i2cm_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  i2cm_front u_front (
    .cmd_i        (cmd_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  i2cm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg_i),
    .rsp_o       (rsp_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master byte engine: predicts pins, busy, done,
// rx byte and NACK for every item and checks them under random stalls on both sides.
// Depends on i2cm_pkg, the channel interfaces and i2c_master_byte_engine_top.
module tb;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 60;
  // Unused command codes; the engine treats them as plain ticks.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic              scl;
    logic              pull;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              nack;
  } pin_step_t;

  class pin_step_scoreboard;
    logic [BYTE_W-1:0]    phase_ticks;
    logic [BYTE_W-1:0]    tick_count;
    logic [PHASE_W-1:0]   phase_idx;
    logic [BIT_CNT_W-1:0] bits_done;
    logic [BYTE_W-1:0]    shifter;
    logic [CMD_W-1:0]     active_op;
    logic                 scl;
    logic                 pull;
    logic                 nack;
    logic [BYTE_W-1:0]    rx_hold;
    pin_step_t            pin_steps_due[$];
    int                   errors;
    int                   steps_checked;
    int                   cmds_started[8];

    function new();
      phase_ticks   = PHASE_TICKS_RESET;
      tick_count    = '0;
      phase_idx     = PH_BIT_LOW;
      bits_done     = '0;
      shifter       = '0;
      active_op     = CMD_TICK;
      scl           = 1'b1;
      pull          = 1'b0;
      nack          = 1'b0;
      rx_hold       = '0;
      errors        = 0;
      steps_checked = 0;
      foreach (cmds_started[i]) cmds_started[i] = 0;
    endfunction

    function void set_phase_ticks(logic [BYTE_W-1:0] value);
      phase_ticks = value;
    endfunction

    function bit is_idle();
      return active_op == CMD_TICK;
    endfunction

    function int pending();
      return pin_steps_due.size();
    endfunction

    function bit is_read();
      return active_op == CMD_READ_ACK || active_op == CMD_READ_NACK;
    endfunction

    function void set_pins(logic s, logic p);
      scl  = s;
      pull = p;
    endfunction

    function void enter_phase();
      logic hi;
      hi = phase_idx[0];
      case (active_op)
        CMD_START: set_pins(1'b1, hi);
        CMD_STOP: begin
          if (phase_idx == PH_BIT_LOW) set_pins(1'b0, 1'b1);
          else if (phase_idx == PH_BIT_HIGH) set_pins(1'b1, 1'b1);
          else set_pins(1'b1, 1'b0);
        end
        CMD_WRITE: begin
          if (phase_idx < PH_ACK_LOW) set_pins(hi, !shifter[7]);
          else set_pins(hi, 1'b0);
        end
        default: begin
          if (phase_idx < PH_ACK_LOW) set_pins(hi, 1'b0);
          else set_pins(hi, active_op == CMD_READ_ACK);
        end
      endcase
    endfunction

    // Close the current phase; return 1 when the command has completed.
    function bit end_phase(logic sda);
      if (active_op == CMD_START) begin
        if (phase_idx == PH_BIT_LOW) begin
          phase_idx = PH_BIT_HIGH;
          return 1'b0;
        end
        set_pins(1'b0, 1'b1);
        return 1'b1;
      end
      // stop runs three phases; its last one shares index 2
      if (active_op == CMD_STOP) begin
        if (phase_idx != PH_ACK_LOW) begin
          phase_idx++;
          return 1'b0;
        end
        return 1'b1;
      end
      if (phase_idx == PH_BIT_LOW || phase_idx == PH_ACK_LOW) begin
        phase_idx++;
        return 1'b0;
      end
      if (phase_idx == PH_BIT_HIGH) begin
        shifter = {shifter[6:0], is_read() ? sda : 1'b0};
        bits_done++;
        phase_idx = (bits_done >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
        return 1'b0;
      end
      if (is_read()) rx_hold = shifter;
      else nack = sda;
      set_pins(1'b0, 1'b0);
      return 1'b1;
    endfunction

    function void note_item(item_t it);
      logic [BYTE_W-1:0] lim;
      pin_step_t         want;
      lim  = (phase_ticks == '0) ? 8'd1 : phase_ticks;
      want = '0;
      if (active_op == CMD_TICK && it.op >= CMD_START && it.op <= CMD_READ_NACK) begin
        active_op  = it.op;
        phase_idx  = PH_BIT_LOW;
        tick_count = '0;
        bits_done  = '0;
        shifter    = (it.op == CMD_WRITE) ? it.tx_byte : '0;
        cmds_started[it.op]++;
        enter_phase();
      end
      want.scl  = scl;
      want.pull = pull;
      if (active_op != CMD_TICK) begin
        want.busy = 1'b1;
        tick_count++;
        if (tick_count >= lim) begin
          tick_count = '0;
          if (end_phase(it.sda_sample)) begin
            want.done = 1'b1;
            active_op = CMD_TICK;
            phase_idx = PH_BIT_LOW;
            bits_done = '0;
          end else begin
            enter_phase();
          end
        end
      end
      want.rx   = rx_hold;
      want.nack = nack;
      pin_steps_due.push_back(want);
    endfunction

    function int field_diff(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_step(pin_step_t got);
      pin_step_t want;
      if (pin_steps_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      want = pin_steps_due.pop_front();
      steps_checked++;
      errors += field_diff("scl_level", want.scl, got.scl);
      errors += field_diff("sda_pull_low", want.pull, got.pull);
      errors += field_diff("engine_busy", want.busy, got.busy);
      errors += field_diff("cmd_done", want.done, got.done);
      errors += field_diff("rx_byte", want.rx, got.rx);
      errors += field_diff("nack_seen", want.nack, got.nack);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  i2cm_cmd_if cmd_ch ();
  i2cm_cfg_if cfg_ch ();
  i2cm_rsp_if rsp_ch ();

  pin_step_scoreboard sb = new();
  bit idle_on;
  bit long_hold_due;
  int items_sent;
  int tick_lengths_run;
  int quiet_cycles;

  i2c_master_byte_engine_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .cfg_i  (cfg_ch),
    .rsp_o  (rsp_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic item_t make_item(logic [CMD_W-1:0] op);
    item_t it;
    it.op = op;
    case ($urandom_range(0, 3))
      0: it.tx_byte = 8'h00;
      1: it.tx_byte = 8'hFF;
      default: it.tx_byte = 8'($urandom);
    endcase
    it.sda_sample = 1'($urandom);
    return it;
  endfunction

  // Idle: mostly real commands. Busy: mostly ticks, some commands that get ignored.
  function automatic logic [CMD_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sb.is_idle()) begin
      if (roll < 65) return 3'($urandom_range(CMD_START, CMD_READ_NACK));
      if (roll < 90) return CMD_TICK;
      return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    if (roll < 92) return CMD_TICK;
    return 3'($urandom_range(CMD_START, CMD_SPARE_7));
  endfunction

  task automatic send_item(input item_t it);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= it.op;
    cmd_ch.tx_byte    <= it.tx_byte;
    cmd_ch.sda_sample <= it.sda_sample;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_item(it);
    items_sent++;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic finish_command();
    while (!sb.is_idle()) send_item(make_item(CMD_TICK));
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(make_item(pick_op()));
    finish_command();
  endtask

  task automatic write_phase_ticks(input logic [BYTE_W-1:0] value);
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.phase_ticks <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_phase_ticks(value);
    tick_lengths_run++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_ni             = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_TICK;
    cmd_ch.tx_byte     = '0;
    cmd_ch.sda_sample  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.phase_ticks = PHASE_TICKS_RESET;
    idle_on            = 1'b1;
    long_hold_due      = 1'b0;
    items_sent         = 0;
    tick_lengths_run   = 1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // idle ticks and unused codes at the reset phase length, then start and stop
    send_item(make_item(CMD_TICK));
    send_item(make_item(CMD_SPARE_6));
    send_item(make_item(CMD_SPARE_7));
    send_item(make_item(CMD_START));
    send_item(make_item(CMD_WRITE));
    finish_command();
    send_item(make_item(CMD_STOP));
    finish_command();

    write_phase_ticks(8'd1);
    long_hold_due = 1'b1;
    run_random(700);
    write_phase_ticks(8'd0);
    run_random(150);
    // longest phase: one start is already hundreds of ticks
    write_phase_ticks(8'd255);
    idle_on = 1'b0;
    send_item(make_item(CMD_START));
    finish_command();
    idle_on = 1'b1;
    write_phase_ticks(8'd2);
    run_random(400);
    write_phase_ticks(8'd5);
    idle_on = 1'b0;
    run_random(250);

    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Sent %0d command-channel items over %0d phase lengths, checked %0d results.",
             items_sent, tick_lengths_run, sb.steps_checked);
    $display("Commands run: start %0d, stop %0d, write %0d, read-ack %0d, read-nack %0d.",
             sb.cmds_started[CMD_START], sb.cmds_started[CMD_STOP],
             sb.cmds_started[CMD_WRITE], sb.cmds_started[CMD_READ_ACK],
             sb.cmds_started[CMD_READ_NACK]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_due) begin
        // hold off long enough for the queue to fill and stall the command side
        long_hold_due = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    pin_step_t got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got.scl  = rsp_ch.scl_level;
      got.pull = rsp_ch.sda_pull_low;
      got.busy = rsp_ch.engine_busy;
      got.done = rsp_ch.cmd_done;
      got.rx   = rsp_ch.rx_byte;
      got.nack = rsp_ch.nack_seen;
      sb.check_step(got);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still due",
               $time, quiet_cycles, sb.pending());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### i2c_master_byte_engine_top.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_if.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_queue.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_byte_engine_top.sv
tb/tb.sv
